### rtl/core/ps2d_pkg.sv
// Shared types and constants for the PS/2 set 2 scan code decoder.
package ps2d_pkg;

  localparam int ByteW = 8;
  localparam int PhaseW = 4;
  localparam int StatusW = 2;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [PhaseW-1:0] phase_t;
  typedef logic [StatusW-1:0] status_t;

  // Prefix grammar positions
  localparam phase_t PH_IDLE   = 4'd0;
  localparam phase_t PH_REL    = 4'd1;
  localparam phase_t PH_EXT    = 4'd2;
  localparam phase_t PH_EXTREL = 4'd3;
  localparam phase_t PH_PSM1   = 4'd4;
  localparam phase_t PH_PSB1   = 4'd5;
  localparam phase_t PH_PSM2   = 4'd6;
  localparam phase_t PH_PSB2   = 4'd7;
  localparam phase_t PH_PSB3   = 4'd8;

  // Scan code bytes
  localparam byte_t B_REL   = 8'hF0;
  localparam byte_t B_EXT   = 8'hE0;
  localparam byte_t B_LSHFT = 8'h12;
  localparam byte_t B_KPMUL = 8'h7C;

  // Result status codes
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_UNKNOWN = 2'd1;
  localparam status_t ST_BAD     = 2'd2;
  localparam status_t ST_RSVD    = 2'd3;

  typedef struct packed {
    byte_t   key_byte;
    logic    released;
    logic    is_extended;
    logic    is_print_screen;
    status_t status;
  } ps2d_event_t;

endpackage

### rtl/core/ps2d_if.sv
// Valid/ready channel interfaces for scan code bytes and key events.
interface ps2d_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ps2d_ev_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_byte;
  logic       released;
  logic       is_extended;
  logic       is_print_screen;
  logic [1:0] status;

  modport source (
    output valid, output key_byte, output released, output is_extended,
    output is_print_screen, output status, input ready
  );
  modport sink (
    input valid, input key_byte, input released, input is_extended,
    input is_print_screen, input status, output ready
  );
endinterface

### rtl/core/ps2_scan_code_decoder_unit.sv
// Top level of the PS/2 set 2 scan code decoder.
//
//   channel  dir  payload                                                 request
//   rx       in   rx_byte                                                 one byte
//   ev       out  key_byte released is_extended is_print_screen status    one key event
//
// One byte per cycle unless ev stalls: input register, decode, result register.
// Prefix bytes produce no event; every other byte produces exactly one.
// rst is synchronous and returns the decoder to idle with both registers empty.
// A stalled ev holds the result; rx keeps accepting while the result register
// frees in the same cycle.
module ps2_scan_code_decoder_unit (
  input logic    clk,
  input logic    rst,
  ps2d_rx_if.sink   rx,
  ps2d_ev_if.source ev
);
  import ps2d_pkg::*;

  logic        s1_valid;
  byte_t       s1_byte;
  logic        s1_adv;
  logic        out_free;
  logic        seq_emit;
  ps2d_event_t seq_ev;
  logic        out_valid;
  ps2d_event_t out_ev;

  assign out_free = !out_valid || ev.ready;
  assign s1_adv   = s1_valid && out_free;
  assign rx.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s1_byte <= rx.rx_byte;
    end
  end

  ps2d_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .adv     (s1_adv),
    .code    (s1_byte),
    .emit    (seq_emit),
    .ev_data (seq_ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_adv && seq_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && seq_emit) begin
      out_ev <= seq_ev;
    end
  end

  assign ev.valid           = out_valid;
  assign ev.key_byte        = out_ev.key_byte;
  assign ev.released        = out_ev.released;
  assign ev.is_extended     = out_ev.is_extended;
  assign ev.is_print_screen = out_ev.is_print_screen;
  assign ev.status          = out_ev.status;

endmodule

### rtl/core/ps2d_lookup.sv
// Base and extended key table membership check.
module ps2d_lookup (
  input  ps2d_pkg::byte_t code,
  input  logic            ext,
  output logic            known
);
  import ps2d_pkg::*;

  logic in_base;
  logic in_ext;

  always_comb begin
    unique case (code) inside
      8'h01, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0C,
      8'h0D, 8'h0E, 8'h11, 8'h12, 8'h14, 8'h15, 8'h16, 8'h1A, 8'h1B, 8'h1C,
      8'h1D, 8'h1E, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h29, 8'h2A,
      8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
      8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45,
      8'h46, 8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h52, 8'h54, 8'h55,
      8'h58, 8'h59, 8'h5A, 8'h5B, 8'h5D, 8'h66, 8'h69, 8'h6B, 8'h6C, 8'h70,
      8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7A,
      8'h7B, 8'h7C, 8'h7D, 8'h7E, 8'h83: in_base = 1'b1;
      default: in_base = 1'b0;
    endcase
  end

  always_comb begin
    unique case (code) inside
      8'h11, 8'h14, 8'h1F, 8'h27, 8'h2F, 8'h4A, 8'h5A, 8'h69, 8'h6B, 8'h6C,
      8'h70, 8'h71, 8'h72, 8'h74, 8'h75, 8'h7A, 8'h7D: in_ext = 1'b1;
      default: in_ext = 1'b0;
    endcase
  end

  assign known = ext ? in_ext : in_base;

endmodule

### rtl/core/ps2d_seq.sv
// Prefix sequence state and key event formation for one scan code byte.
module ps2d_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  ps2d_pkg::byte_t       code,
  output logic                  emit,
  output ps2d_pkg::ps2d_event_t ev_data
);
  import ps2d_pkg::*;

  phase_t phase;
  phase_t phase_next;
  logic   ext_lookup;
  logic   known;

  assign ext_lookup = (phase == PH_EXT) || (phase == PH_EXTREL);

  ps2d_lookup u_lookup (
    .code  (code),
    .ext   (ext_lookup),
    .known (known)
  );

  always_comb begin
    phase_next              = PH_IDLE;
    emit                    = 1'b1;
    ev_data.key_byte        = code;
    ev_data.released        = 1'b0;
    ev_data.is_extended     = 1'b0;
    ev_data.is_print_screen = 1'b0;
    ev_data.status          = ST_BAD;
    unique case (phase)
      PH_REL: begin
        ev_data.released = 1'b1;
        ev_data.status   = known ? ST_OK : ST_UNKNOWN;
      end
      PH_EXT: begin
        if (code == B_REL) begin
          phase_next = PH_EXTREL;
          emit       = 1'b0;
        end else if (code == B_LSHFT) begin
          phase_next = PH_PSM1;
          emit       = 1'b0;
        end else begin
          ev_data.is_extended = 1'b1;
          ev_data.status      = known ? ST_OK : ST_UNKNOWN;
        end
      end
      PH_EXTREL: begin
        if (code == B_KPMUL) begin
          phase_next = PH_PSB1;
          emit       = 1'b0;
        end else begin
          ev_data.released    = 1'b1;
          ev_data.is_extended = 1'b1;
          ev_data.status      = known ? ST_OK : ST_UNKNOWN;
        end
      end
      PH_PSM1: begin
        if (code == B_EXT) begin
          phase_next = PH_PSM2;
          emit       = 1'b0;
        end
      end
      PH_PSM2: begin
        if (code == B_KPMUL) begin
          ev_data.key_byte        = '0;
          ev_data.is_print_screen = 1'b1;
          ev_data.status          = ST_OK;
        end
      end
      PH_PSB1: begin
        if (code == B_EXT) begin
          phase_next = PH_PSB2;
          emit       = 1'b0;
        end
      end
      PH_PSB2: begin
        if (code == B_REL) begin
          phase_next = PH_PSB3;
          emit       = 1'b0;
        end
      end
      PH_PSB3: begin
        if (code == B_LSHFT) begin
          ev_data.key_byte        = '0;
          ev_data.released        = 1'b1;
          ev_data.is_print_screen = 1'b1;
          ev_data.status          = ST_OK;
        end
      end
      default: begin
        // idle, and unreachable codes act as idle
        if (code == B_REL) begin
          phase_next = PH_REL;
          emit       = 1'b0;
        end else if (code == B_EXT) begin
          phase_next = PH_EXT;
          emit       = 1'b0;
        end else begin
          ev_data.status = known ? ST_OK : ST_UNKNOWN;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (adv) begin
      phase <= phase_next;
    end
  end

endmodule

### rtl/core/ps2d_checker.sv
// Port-level checks for the scan code decoder, bound to the top level.
module ps2d_checker (
  input logic       clk,
  input logic       rst,
  input logic       ev_valid,
  input logic       ev_ready,
  input logic [7:0] key_byte,
  input logic       released,
  input logic       is_extended,
  input logic       is_print_screen,
  input logic [1:0] status
);
  import ps2d_pkg::*;

  a_reset_clears: assert property (@(posedge clk) rst |=> !ev_valid)
    else $error("event valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    ev_valid && !ev_ready |=> ev_valid && $stable(key_byte) && $stable(status))
    else $error("stalled event changed");

  a_bad_flags: assert property (@(posedge clk) disable iff (rst)
    ev_valid && status == ST_BAD |-> !released && !is_extended && !is_print_screen)
    else $error("bad sequence event carries flags");

  a_prtsc: assert property (@(posedge clk) disable iff (rst)
    ev_valid && is_print_screen |-> key_byte == '0 && !is_extended && status == ST_OK)
    else $error("malformed print screen event");

  a_status: assert property (@(posedge clk) disable iff (rst)
    ev_valid |-> status != ST_RSVD)
    else $error("reserved status code");

endmodule

bind ps2_scan_code_decoder_unit ps2d_checker u_ps2d_checker (
  .clk             (clk),
  .rst             (rst),
  .ev_valid        (ev.valid),
  .ev_ready        (ev.ready),
  .key_byte        (ev.key_byte),
  .released        (ev.released),
  .is_extended     (ev.is_extended),
  .is_print_screen (ev.is_print_screen),
  .status          (ev.status)
);

### test/tb_top.sv
// Self-checking testbench for the PS/2 set 2 scan code decoder unit.
module tb_top;
  import ps2d_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int SettleCycles = 10;

  logic clk;
  logic rst;

  ps2d_rx_if rx_ch();
  ps2d_ev_if ev_ch();

  ps2_scan_code_decoder_unit dut (
    .clk(clk),
    .rst(rst),
    .rx(rx_ch),
    .ev(ev_ch)
  );

  phase_t grammar_pos = PH_IDLE;
  ps2d_event_t expected_events[$];

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int error_count = 0;
  int bytes_sent = 0;
  int events_checked = 0;
  int print_screen_seen = 0;
  int unknown_seen = 0;
  int bad_seq_seen = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic status_t key_status(input byte_t b, input logic ext);
    logic known;
    known = 1'b0;
    if (ext) begin
      case (b)
        8'h11, 8'h14, 8'h1F, 8'h27, 8'h2F, 8'h4A, 8'h5A, 8'h69, 8'h6B,
        8'h6C, 8'h70, 8'h71, 8'h72, 8'h74, 8'h75, 8'h7A, 8'h7D: known = 1'b1;
        default: known = 1'b0;
      endcase
    end else begin
      case (b)
        8'h01, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h09, 8'h0A, 8'h0B,
        8'h0C, 8'h0D, 8'h0E, 8'h11, 8'h12, 8'h14, 8'h15, 8'h16, 8'h1A,
        8'h1B, 8'h1C, 8'h1D, 8'h1E, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25,
        8'h26, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h31, 8'h32,
        8'h33, 8'h34, 8'h35, 8'h36, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E,
        8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h49, 8'h4A, 8'h4B,
        8'h4C, 8'h4D, 8'h4E, 8'h52, 8'h54, 8'h55, 8'h58, 8'h59, 8'h5A,
        8'h5B, 8'h5D, 8'h66, 8'h69, 8'h6B, 8'h6C, 8'h70, 8'h71, 8'h72,
        8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7A, 8'h7B,
        8'h7C, 8'h7D, 8'h7E, 8'h83: known = 1'b1;
        default: known = 1'b0;
      endcase
    end
    return known ? ST_OK : ST_UNKNOWN;
  endfunction

  // Advance the prefix grammar by one byte; queue the key event it completes.
  function automatic void decode_scan_byte(input byte_t b);
    ps2d_event_t ev_exp;
    logic produces;
    phase_t next_pos;
    produces = 1'b1;
    next_pos = PH_IDLE;
    ev_exp = '0;
    ev_exp.key_byte = b;
    ev_exp.status = ST_BAD;
    case (grammar_pos)
      PH_REL: begin
        ev_exp.released = 1'b1;
        ev_exp.status = key_status(b, 1'b0);
      end
      PH_EXT: begin
        if (b == B_REL) begin
          produces = 1'b0;
          next_pos = PH_EXTREL;
        end else if (b == B_LSHFT) begin
          produces = 1'b0;
          next_pos = PH_PSM1;
        end else begin
          ev_exp.is_extended = 1'b1;
          ev_exp.status = key_status(b, 1'b1);
        end
      end
      PH_EXTREL: begin
        if (b == B_KPMUL) begin
          produces = 1'b0;
          next_pos = PH_PSB1;
        end else begin
          ev_exp.released = 1'b1;
          ev_exp.is_extended = 1'b1;
          ev_exp.status = key_status(b, 1'b1);
        end
      end
      PH_PSM1: begin
        if (b == B_EXT) begin
          produces = 1'b0;
          next_pos = PH_PSM2;
        end
      end
      PH_PSM2: begin
        if (b == B_KPMUL) begin
          ev_exp.key_byte = '0;
          ev_exp.is_print_screen = 1'b1;
          ev_exp.status = ST_OK;
        end
      end
      PH_PSB1: begin
        if (b == B_EXT) begin
          produces = 1'b0;
          next_pos = PH_PSB2;
        end
      end
      PH_PSB2: begin
        if (b == B_REL) begin
          produces = 1'b0;
          next_pos = PH_PSB3;
        end
      end
      PH_PSB3: begin
        if (b == B_LSHFT) begin
          ev_exp.key_byte = '0;
          ev_exp.released = 1'b1;
          ev_exp.is_print_screen = 1'b1;
          ev_exp.status = ST_OK;
        end
      end
      default: begin
        if (b == B_REL) begin
          produces = 1'b0;
          next_pos = PH_REL;
        end else if (b == B_EXT) begin
          produces = 1'b0;
          next_pos = PH_EXT;
        end else begin
          ev_exp.status = key_status(b, 1'b0);
        end
      end
    endcase
    if (produces) expected_events.push_back(ev_exp);
    grammar_pos = next_pos;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %02h expected %02h", name, got, want));
  endtask

  // Event checker
  always @(posedge clk) begin
    ps2d_event_t got;
    ps2d_event_t want;
    if (!rst && ev_ch.valid && ev_ch.ready) begin
      got.key_byte = ev_ch.key_byte;
      got.released = ev_ch.released;
      got.is_extended = ev_ch.is_extended;
      got.is_print_screen = ev_ch.is_print_screen;
      got.status = ev_ch.status;
      if (expected_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event key_byte %02h status %0d",
                                  got.key_byte, got.status));
      end else begin
        want = expected_events.pop_front();
        events_checked++;
        if (want.is_print_screen) print_screen_seen++;
        if (want.status == ST_UNKNOWN) unknown_seen++;
        if (want.status == ST_BAD) bad_seq_seen++;
        check_field("key_byte", got.key_byte, want.key_byte);
        check_field("released", 8'(got.released), 8'(want.released));
        check_field("is_extended", 8'(got.is_extended), 8'(want.is_extended));
        check_field("is_print_screen", 8'(got.is_print_screen), 8'(want.is_print_screen));
        check_field("status", 8'(got.status), 8'(want.status));
      end
    end
  end

  always @(posedge clk) begin
    ev_ch.ready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (ev_ch.valid && ev_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("Timeout: no request moved for %0d cycles", QuietLimit);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_byte(input byte_t b);
    if ($urandom_range(99) < src_idle_pct) begin
      rx_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    decode_scan_byte(b);
    bytes_sent++;
  endtask

  task automatic wait_events_drained();
    rx_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_events.size() != 0);
  endtask

  function automatic byte_t pick_key(input logic ext);
    byte_t b;
    b = byte_t'($urandom_range(255));
    if ($urandom_range(9) < 7)
      while (key_status(b, ext) != ST_OK) b = byte_t'($urandom_range(255));
    return b;
  endfunction

  task automatic test_plain_keys();
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  task automatic test_release_prefix();
    send_byte(B_REL);
    send_byte(8'h1C);
  endtask

  // E0 F0 12 is an extended release of a code missing from the table
  task automatic test_doubled_prefix();
    send_byte(B_EXT);
    send_byte(B_REL);
    send_byte(B_LSHFT);
  endtask

  task automatic test_print_screen();
    send_byte(B_EXT);
    send_byte(B_LSHFT);
    send_byte(B_EXT);
    send_byte(B_KPMUL);
    send_byte(B_EXT);
    send_byte(B_REL);
    send_byte(B_KPMUL);
    send_byte(B_EXT);
    send_byte(B_REL);
    send_byte(B_LSHFT);
  endtask

  task automatic test_broken_print_screen();
    send_byte(B_EXT);
    send_byte(B_LSHFT);
    send_byte(8'h00);
    send_byte(B_EXT);
    send_byte(B_REL);
    send_byte(B_KPMUL);
    send_byte(B_EXT);
    send_byte(B_LSHFT);
  endtask

  // Mostly well-formed key events with random content; some corrupted or noise.
  task automatic test_random_traffic(input int src_pct, input int snk_pct, input int n_bytes);
    byte_t burst[$];
    int start_count;
    int pick;
    src_idle_pct = src_pct;
    sink_stall_pct = snk_pct;
    start_count = bytes_sent;
    while (bytes_sent - start_count < n_bytes) begin
      burst.delete();
      pick = $urandom_range(99);
      if (pick < 20) begin
        burst.push_back(pick_key(1'b0));
      end else if (pick < 35) begin
        burst.push_back(B_REL);
        burst.push_back(pick_key(1'b0));
      end else if (pick < 50) begin
        burst.push_back(B_EXT);
        burst.push_back(pick_key(1'b1));
      end else if (pick < 62) begin
        burst.push_back(B_EXT);
        burst.push_back(B_REL);
        burst.push_back(pick_key(1'b1));
      end else if (pick < 86) begin
        burst.push_back(B_EXT);
        if (pick < 74) begin
          burst.push_back(B_LSHFT);
          burst.push_back(B_EXT);
          burst.push_back(B_KPMUL);
        end else begin
          burst.push_back(B_REL);
          burst.push_back(B_KPMUL);
          burst.push_back(B_EXT);
          burst.push_back(B_REL);
          burst.push_back(B_LSHFT);
        end
        if ($urandom_range(3) == 0)
          burst[$urandom_range(burst.size() - 1, 1)] = byte_t'($urandom_range(255));
      end else begin
        repeat ($urandom_range(3, 1)) burst.push_back(byte_t'($urandom_range(255)));
      end
      foreach (burst[i]) send_byte(burst[i]);
    end
    wait_events_drained();
  endtask

  initial begin
    rst = 1'b1;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = '0;
    ev_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_plain_keys();
    test_release_prefix();
    test_doubled_prefix();
    test_print_screen();
    test_broken_print_screen();
    wait_events_drained();

    test_random_traffic(0, 0, 130);
    test_random_traffic(63, 0, 130);
    test_random_traffic(0, 63, 130);
    test_random_traffic(36, 36, 130);

    repeat (SettleCycles) @(posedge clk);
    if (expected_events.size() != 0)
      report_mismatch($sformatf("%0d expected events never arrived", expected_events.size()));

    $display("Sent %0d scan code bytes and checked %0d key events: %0d print screen,",
             bytes_sent, events_checked, print_screen_seen);
    $display("%0d unknown code, %0d bad sequence; idle phases none, sender, receiver, both.",
             unknown_seen, bad_seq_seen);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
